// ===== rtl/core/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg
// shared types and constants of the infix expression evaluator
// ----------------------------------------------------------------------------
`default_nettype none
package iee_pkg;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3, OP_LPAREN = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_OVERFLOW = 2'd2, ST_MALFORMED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_IGNORE = 3'd0, K_DIGIT = 3'd1, K_OPER = 3'd2, K_LPAREN = 3'd3, K_RPAREN = 3'd4
    } t_kind;

    // classified token passed from front to back
    typedef struct packed {
        t_kind      kind;
        t_op        op;
        logic [3:0] digit;
        logic       last;
    } t_token;

    typedef enum logic [2:0] {
        S_IDLE, S_TOKEN, S_APPLY, S_DIV, S_FINISH, S_REPORT
    } t_state;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
endpackage
`default_nettype wire

// ===== rtl/core/iee_if.sv =====
// ----------------------------------------------------------------------------
// iee_in_if / iee_out_if
// valid-ready channels of the evaluator
// ----------------------------------------------------------------------------
`default_nettype none
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;
    modport source (output valid, char_code, is_last, input ready);
    modport sink   (input valid, char_code, is_last, output ready);
endinterface

interface iee_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/iee_front.sv =====
// ----------------------------------------------------------------------------
// iee_front
// classifies characters into tokens and queues them
// ----------------------------------------------------------------------------
`default_nettype none
module iee_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    iee_in_if.sink               in_ch,
    output iee_pkg::t_token      o_tok,
    output logic                 o_tok_valid,
    input  wire logic            i_tok_pop
);
    import iee_pkg::*;
    localparam int AW = $clog2(QUEUE_DEPTH);

    t_token          r_q [QUEUE_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    t_token          n_tok;
    logic            push, pop;

    always_comb begin
        n_tok.kind  = K_IGNORE;
        n_tok.op    = OP_ADD;
        n_tok.digit = in_ch.char_code[3:0];
        n_tok.last  = in_ch.is_last;
        if (in_ch.char_code >= CH_ZERO && in_ch.char_code <= CH_NINE) begin
            n_tok.kind = K_DIGIT;
        end else begin
            unique case (in_ch.char_code)
                CH_PLUS:  begin n_tok.kind = K_OPER; n_tok.op = OP_ADD; end
                CH_MINUS: begin n_tok.kind = K_OPER; n_tok.op = OP_SUB; end
                CH_STAR:  begin n_tok.kind = K_OPER; n_tok.op = OP_MUL; end
                CH_SLASH: begin n_tok.kind = K_OPER; n_tok.op = OP_DIV; end
                CH_LPAR:  n_tok.kind = K_LPAREN;
                CH_RPAR:  n_tok.kind = K_RPAREN;
                default:  n_tok.kind = K_IGNORE;
            endcase
        end
    end

    assign in_ch.ready = (r_cnt != (AW+1)'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign o_tok_valid = (r_cnt != '0);
    assign pop         = i_tok_pop && o_tok_valid;
    assign o_tok       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_tok;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/iee_divider.sv =====
// ----------------------------------------------------------------------------
// iee_divider
// restoring divider, one quotient bit a cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none
module iee_divider #(
    parameter int VALUE_BITS = iee_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_a,
    input  wire logic [VALUE_BITS-1:0] i_b,
    output logic                       o_done,
    output logic [VALUE_BITS-1:0]      o_q
);
    localparam int CW = $clog2(VALUE_BITS + 1);
    logic [VALUE_BITS-1:0] r_q, r_d;
    logic [VALUE_BITS:0]   r_rem, trial, shifted;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy, r_neg, r_done;

    assign shifted = {r_rem[VALUE_BITS-1:0], r_q[VALUE_BITS-1]};
    assign trial   = shifted - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin r_busy <= 1'b0; r_done <= 1'b1; end
            end
        end
        if (i_start) begin
            r_q   <= i_a[VALUE_BITS-1] ? -i_a : i_a;
            r_d   <= i_b[VALUE_BITS-1] ? -i_b : i_b;
            r_rem <= '0;
            r_neg <= i_a[VALUE_BITS-1] ^ i_b[VALUE_BITS-1];
        end else if (r_busy) begin
            if (!trial[VALUE_BITS]) begin
                r_rem <= trial;
                r_q   <= {r_q[VALUE_BITS-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_q   <= {r_q[VALUE_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? -r_q : r_q;
endmodule
`default_nettype wire

// ===== rtl/core/iee_back.sv =====
// ----------------------------------------------------------------------------
// iee_back
// stack machine that applies tokens and reports results
// ----------------------------------------------------------------------------
`default_nettype none
module iee_back #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_BITS  = iee_pkg::VALUE_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire iee_pkg::t_token i_tok,
    input  wire logic            i_tok_valid,
    output logic                 o_tok_pop,
    iee_out_if.source            out_ch
);
    import iee_pkg::*;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [VALUE_BITS-1:0] r_vs [STACK_DEPTH];
    t_op                   r_os [STACK_DEPTH];
    logic [CW-1:0]         r_vc, n_vc, r_oc, n_oc;
    t_status               r_st, n_st;
    t_state                r_state, n_state;
    t_token                r_tok, n_tok;
    logic                  r_ov, n_ov;
    logic signed [31:0]    r_res, n_res;
    logic [1:0]            r_ost, n_ost;

    // stack writes
    logic                  v_we, o_we;
    logic [AW-1:0]         v_wa, o_wa;
    logic [VALUE_BITS-1:0] v_wd;
    t_op                   o_wd;

    logic [VALUE_BITS-1:0] va, vb, arith;
    t_op                   top_op;
    logic                  div_start, div_done;
    logic [VALUE_BITS-1:0] div_q;

    assign va     = r_vs[AW'(r_vc - CW'(2))];
    assign vb     = r_vs[AW'(r_vc - CW'(1))];
    assign top_op = r_os[AW'(r_oc - CW'(1))];

    iee_divider #(.VALUE_BITS(VALUE_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_a(va), .i_b(vb), .o_done(div_done), .o_q(div_q)
    );

    always_comb begin
        unique case (top_op)
            OP_ADD:  arith = va + vb;
            OP_SUB:  arith = va - vb;
            OP_MUL:  arith = VALUE_BITS'(va * vb);
            default: arith = va;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_vc <= '0; r_oc <= '0; r_st <= ST_OK; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_vc <= n_vc; r_oc <= n_oc; r_st <= n_st; r_ov <= n_ov;
        end
        r_tok <= n_tok; r_res <= n_res; r_ost <= n_ost;
        if (v_we) r_vs[v_wa] <= v_wd;
        if (o_we) r_os[o_wa] <= o_wd;
    end

    always_comb begin
        n_state = r_state; n_vc = r_vc; n_oc = r_oc; n_st = r_st; n_tok = r_tok;
        n_ov = r_ov; n_res = r_res; n_ost = r_ost;
        o_tok_pop = 1'b0; div_start = 1'b0;
        v_we = 1'b0; v_wa = AW'(r_vc); v_wd = '0;
        o_we = 1'b0; o_wa = AW'(r_oc); o_wd = r_tok.op;
        unique case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    o_tok_pop = 1'b1;
                    n_tok     = i_tok;
                    n_state   = (r_st == ST_OK) ? S_TOKEN : (i_tok.last ? S_FINISH : S_IDLE);
                end
            end
            S_TOKEN: begin
                n_state = r_tok.last ? S_FINISH : S_IDLE;
                unique case (r_tok.kind)
                    K_DIGIT: begin
                        if (r_vc == CW'(STACK_DEPTH)) n_st = ST_OVERFLOW;
                        else begin
                            v_we = 1'b1; v_wd = VALUE_BITS'(r_tok.digit); n_vc = r_vc + 1'b1;
                        end
                    end
                    K_LPAREN: begin
                        if (r_oc == CW'(STACK_DEPTH)) n_st = ST_OVERFLOW;
                        else begin
                            o_we = 1'b1; o_wd = OP_LPAREN; n_oc = r_oc + 1'b1;
                        end
                    end
                    K_RPAREN: begin
                        if (r_oc != '0) begin
                            if (top_op == OP_LPAREN) n_oc = r_oc - 1'b1;
                            else n_state = S_APPLY;
                        end
                    end
                    K_OPER: begin
                        if (r_oc != '0 && top_op != OP_LPAREN &&
                            top_op[2:1] >= r_tok.op[2:1]) begin
                            n_state = S_APPLY;
                        end else if (r_oc == CW'(STACK_DEPTH)) begin
                            n_st = ST_OVERFLOW;
                        end else begin
                            o_we = 1'b1; n_oc = r_oc + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_APPLY: begin
                // pop one operator and apply it, then re-check the token
                n_oc = r_oc - 1'b1;
                if (r_vc < CW'(2)) begin
                    n_st = ST_MALFORMED; n_state = r_tok.last ? S_FINISH : S_IDLE;
                end else if (top_op == OP_DIV) begin
                    if (vb == '0) begin
                        n_st = ST_DIV0; n_state = r_tok.last ? S_FINISH : S_IDLE;
                    end else begin
                        div_start = 1'b1; n_oc = r_oc; n_state = S_DIV;
                    end
                end else begin
                    v_we = 1'b1; v_wa = AW'(r_vc - CW'(2)); v_wd = arith;
                    n_vc = r_vc - 1'b1;
                    n_state = (r_tok.kind == K_IGNORE) ? S_FINISH : S_TOKEN;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    v_we = 1'b1; v_wa = AW'(r_vc - CW'(2)); v_wd = div_q;
                    n_vc = r_vc - 1'b1; n_oc = r_oc - 1'b1;
                    n_state = (r_tok.kind == K_IGNORE) ? S_FINISH : S_TOKEN;
                end
            end
            S_FINISH: begin
                // drain the operator stack; token kind cleared so apply returns here
                n_tok.kind = K_IGNORE; n_tok.last = 1'b1;
                if (r_st == ST_OK && r_oc != '0) begin
                    if (top_op == OP_LPAREN) n_st = ST_MALFORMED;
                    else n_state = S_APPLY;
                end else begin
                    n_state = S_REPORT;
                    if (r_st == ST_OK && r_vc != CW'(1)) begin
                        n_ost = ST_MALFORMED; n_res = '0;
                    end else begin
                        n_ost = r_st;
                        n_res = (r_st == ST_OK) ?
                            32'(signed'(r_vs[0])) : '0;
                    end
                    n_ov = 1'b1;
                end
            end
            S_REPORT: begin
                if (out_ch.ready) begin
                    n_ov = 1'b0; n_state = S_IDLE;
                    n_vc = '0; n_oc = '0; n_st = ST_OK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign out_ch.valid        = r_ov;
    assign out_ch.result_value = r_res;
    assign out_ch.status       = r_ost;
endmodule
`default_nettype wire

// ===== rtl/core/infix_expression_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// shunting-yard evaluator of single-digit infix expressions
// ----------------------------------------------------------------------------
//  channel  dir  payload                        transfer
//  in_ch    in   char_code[7:0], is_last        valid & ready
//  out_ch   out  result_value[31:0], status[1:0] valid & ready
//
//  characters enter a 4-entry token queue at one item a cycle
//  the back end takes each token in an idle state and handles it in a token
//  state; each operator applied adds an apply and a re-check; a division
//  waits in a divide state for the divider; the last item drains operators
//  via apply and finish; the result is valid the cycle after, until taken
//  reset clears both stack counts, status and the queue; stacks hold no reset
//  the front keeps taking items while the back stalls, until the queue is full
// ----------------------------------------------------------------------------
`default_nettype none
module infix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_BITS  = iee_pkg::VALUE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    iee_in_if.sink     in_ch,
    iee_out_if.source  out_ch
);
    import iee_pkg::*;

    t_token tok;
    logic   tok_valid, tok_pop;

    // front: classify and queue
    iee_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_tok(tok), .o_tok_valid(tok_valid), .i_tok_pop(tok_pop)
    );

    // back: stacks, arithmetic, result
    iee_back #(.STACK_DEPTH(STACK_DEPTH), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tok(tok), .i_tok_valid(tok_valid),
        .o_tok_pop(tok_pop), .out_ch(out_ch)
    );

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_value))
        else $error("result changed while stalled");
    // an error result carries a zero value
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.status != ST_OK |-> out_ch.result_value == 32'sd0)
        else $error("error result not zero");
    // no token is taken while a result waits
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !tok_pop)
        else $error("token popped during report");
endmodule
`default_nettype wire
